FILE: rtl/fcce_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FAT cluster chain engine package
// Shared codes, constants and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package fcce_pkg;

  localparam int unsigned ENTRIES_DEF = 4096;

  localparam logic [15:0] FREE_MARK   = 16'h0000;
  localparam logic [15:0] EOC_MARK    = 16'hFFFF;
  localparam logic [15:0] LAST_DATA   = 16'hFFEF;
  localparam logic [15:0] FIRST_DATA  = 16'h0002;
  localparam int unsigned RESERVED_FIRST = 32'hFFF0;

  localparam int unsigned SCAN_LIMIT_W   = 13;
  localparam logic [SCAN_LIMIT_W-1:0] SCAN_LIMIT_RST = 13'd4096;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_ALLOC = 2'd2,
    OP_FREE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2,
    STAT_LONG  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_INPUT,
    IDX_FIRST,
    IDX_INC,
    IDX_LINK
  } idx_op_e;

  typedef enum logic [1:0] {
    WR_ZERO,
    WR_VAL,
    WR_EOC
  } wr_sel_e;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_RDATA,
    RES_IDX
  } res_sel_e;

  typedef struct packed {
    logic     ld_in;
    idx_op_e  idx_op;
    logic     steps_clr;
    logic     steps_inc;
    logic     mem_we;
    wr_sel_e  wr_sel;
    logic     out_load;
    res_sel_e res_sel;
    status_e  status;
  } cmd_t;

  typedef struct packed {
    logic in_range;
    logic chain_ok;
    logic steps_max;
    logic scan_end;
    logic hit;
    logic clear_last;
  } sts_t;

endpackage

FILE: rtl/fcce_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FAT cluster chain engine datapath
// Table memory, cluster pointer, step counter, scan bound and result word.
// ----------------------------------------------------------------------------
module fcce_dpath #(
  parameter int unsigned ENTRIES = fcce_pkg::ENTRIES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  fcce_pkg::cmd_t                      cmd_i,
  output fcce_pkg::sts_t                      sts_o,
  input  logic [15:0]                         cluster_index_i,
  input  logic [15:0]                         entry_value_i,
  input  logic                                cfg_we_i,
  input  logic [fcce_pkg::SCAN_LIMIT_W-1:0]   cfg_data_i,
  output logic [15:0]                         result_value_o,
  output logic [1:0]                          status_o
);
  import fcce_pkg::*;

  localparam int unsigned AW = $clog2(ENTRIES);
  localparam int unsigned SW = AW + 1;
  localparam logic [15:0] ENT16 = 16'(ENTRIES);
  localparam logic [15:0] LAST_IDX = 16'(ENTRIES - 1);
  localparam logic [15:0] CAP =
    16'((ENTRIES < RESERVED_FIRST) ? ENTRIES : RESERVED_FIRST);
  localparam logic [SW-1:0] STEPS_MAX = SW'(ENTRIES);

  logic [15:0]             mem [ENTRIES];
  logic [15:0]             rdata_q;
  logic [15:0]             idx_q, idx_d;
  logic [15:0]             val_q;
  logic [SW-1:0]           steps_q, steps_d;
  logic [SCAN_LIMIT_W-1:0] scan_limit_q;
  logic [15:0]             result_q;
  logic [1:0]              status_q;
  logic [15:0]             lim16;
  logic [15:0]             scan_end_val;
  logic [15:0]             wdata;
  logic [15:0]             res_mux;

  always_comb begin
    unique case (cmd_i.idx_op)
      IDX_INPUT: idx_d = cluster_index_i;
      IDX_FIRST: idx_d = FIRST_DATA;
      IDX_INC:   idx_d = idx_q + 16'd1;
      IDX_LINK:  idx_d = rdata_q;
      default:   idx_d = idx_q;
    endcase
  end

  always_comb begin
    steps_d = steps_q;
    if (cmd_i.steps_clr) begin
      steps_d = '0;
    end else if (cmd_i.steps_inc) begin
      steps_d = steps_q + SW'(1);
    end
  end

  always_comb begin
    unique case (cmd_i.wr_sel)
      WR_VAL:  wdata = val_q;
      WR_EOC:  wdata = EOC_MARK;
      default: wdata = FREE_MARK;
    endcase
  end

  always_comb begin
    unique case (cmd_i.res_sel)
      RES_RDATA: res_mux = rdata_q;
      RES_IDX:   res_mux = idx_q;
      default:   res_mux = FREE_MARK;
    endcase
  end

  // Allocate bound: smallest of the register, the table depth and the reserved range
  assign lim16        = {{(16 - SCAN_LIMIT_W){1'b0}}, scan_limit_q};
  assign scan_end_val = (lim16 < CAP) ? lim16 : CAP;

  assign sts_o.in_range   = idx_q < ENT16;
  assign sts_o.chain_ok   = (idx_q >= FIRST_DATA) && (idx_q <= LAST_DATA);
  assign sts_o.steps_max  = steps_q == STEPS_MAX;
  assign sts_o.scan_end   = idx_q >= scan_end_val;
  assign sts_o.hit        = rdata_q == FREE_MARK;
  assign sts_o.clear_last = idx_q == LAST_IDX;

  // Read at the next pointer so that rdata_q follows the entry under idx_q
  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we) begin
      mem[idx_q[AW-1:0]] <= wdata;
    end
    rdata_q <= mem[idx_d[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q        <= '0;
      steps_q      <= '0;
      scan_limit_q <= SCAN_LIMIT_RST;
    end else begin
      idx_q   <= idx_d;
      steps_q <= steps_d;
      if (cfg_we_i) begin
        scan_limit_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_in) begin
      val_q <= entry_value_i;
    end
    if (cmd_i.out_load) begin
      result_q <= res_mux;
      status_q <= cmd_i.status;
    end
  end

  assign result_value_o = result_q;
  assign status_o       = status_q;

endmodule

FILE: rtl/fcce_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FAT cluster chain engine controller
// Sequences the clearing pass, the four operations and the output word.
// ----------------------------------------------------------------------------
module fcce_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic [1:0]     operation_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output fcce_pkg::cmd_t cmd_o,
  input  fcce_pkg::sts_t sts_i
);
  import fcce_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_WR    = 3'd3;
  localparam logic [2:0] S_ALLOC = 3'd4;
  localparam logic [2:0] S_FCHK  = 3'd5;
  localparam logic [2:0] S_FUPD  = 3'd6;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;
  op_e        op;

  assign op       = op_e'(operation_i);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d   = state_q;
    cmd_o     = '{ld_in: 1'b0, idx_op: IDX_HOLD, steps_clr: 1'b0, steps_inc: 1'b0,
                  mem_we: 1'b0, wr_sel: WR_ZERO, out_load: 1'b0, res_sel: RES_ZERO,
                  status: STAT_OK};
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.mem_we = 1'b1;
        cmd_o.idx_op = IDX_INC;
        if (sts_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.ld_in     = 1'b1;
          cmd_o.steps_clr = 1'b1;
          cmd_o.idx_op    = IDX_INPUT;
          unique case (op)
            OP_READ:  state_d = S_RD;
            OP_WRITE: state_d = S_WR;
            OP_ALLOC: begin
              cmd_o.idx_op = IDX_FIRST;
              state_d      = S_ALLOC;
            end
            OP_FREE:  state_d = S_FCHK;
          endcase
        end
      end
      S_RD: begin
        cmd_o.res_sel = sts_i.in_range ? RES_RDATA : RES_ZERO;
        cmd_o.status  = sts_i.in_range ? STAT_OK : STAT_RANGE;
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_WR: begin
        cmd_o.wr_sel = WR_VAL;
        cmd_o.status = sts_i.in_range ? STAT_OK : STAT_RANGE;
        if (out_free) begin
          cmd_o.mem_we   = sts_i.in_range;
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_ALLOC: begin
        priority if (sts_i.scan_end) begin
          cmd_o.status = STAT_FULL;
          if (out_free) begin
            cmd_o.out_load = 1'b1;
            state_d        = S_IDLE;
          end
        end else if (sts_i.hit) begin
          cmd_o.wr_sel  = WR_EOC;
          cmd_o.res_sel = RES_IDX;
          if (out_free) begin
            cmd_o.mem_we   = 1'b1;
            cmd_o.out_load = 1'b1;
            state_d        = S_IDLE;
          end
        end else begin
          cmd_o.idx_op = IDX_INC;
        end
      end
      S_FCHK: begin
        priority if (!sts_i.chain_ok) begin
          cmd_o.status = STAT_OK;
        end else if (!sts_i.in_range) begin
          cmd_o.status = STAT_RANGE;
        end else if (sts_i.steps_max) begin
          cmd_o.status = STAT_LONG;
        end else begin
          state_d = S_FUPD;
        end
        if (state_d == S_FCHK && out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_FUPD: begin
        cmd_o.mem_we    = 1'b1;
        cmd_o.wr_sel    = WR_ZERO;
        cmd_o.idx_op    = IDX_LINK;
        cmd_o.steps_inc = 1'b1;
        state_d         = S_FCHK;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;

`ifndef SYNTH
  a_load_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || !out_stall_i))
    else $error("result loaded over an untaken word");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.mem_we |-> sts_i.in_range)
    else $error("table write outside the table");

  a_clear_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLEAR |-> in_stall_o)
    else $error("input taken during clearing pass");

  a_free_step_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FUPD |-> (sts_i.chain_ok && sts_i.in_range && !sts_i.steps_max))
    else $error("chain step taken past a stop condition");

  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) != S_IDLE && $past(state_q) != S_CLEAR)
    else $error("result word without an operation");
`endif

endmodule

FILE: rtl/fat_cluster_chain_engine_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FAT cluster chain engine
// On-chip FAT16 allocation table with read, write, allocate and free chain.
// ----------------------------------------------------------------------------
// Holds an ENTRIES-deep table of 16-bit FAT entries in a memory with one write
// port and one read port, and serves one request at a time, giving exactly one
// result word per request. After reset the block sweeps the table to zero, one
// entry per cycle, holding in_stall_o high until the sweep is done; the
// scan_limit register may be written during that time. Allocate steps past each
// taken entry from cluster 2 upward, bounded by the smallest of scan_limit,
// ENTRIES and the start of the reserved range. Free chain clears one entry at a
// time, since each link must come out of the memory before the next address is
// known. A new request is taken as soon as the engine is idle, even while the
// last result word still waits on out_stall_i; the engine then finishes its
// work and holds until the output register frees. Status codes: ok, table full
// on a failed allocate, index out of range for a bad read/write index or a bad
// link in a chain, chain too long when a free walk clears ENTRIES entries
// without reaching an end mark.
// ----------------------------------------------------------------------------
module fat_cluster_chain_engine_core #(
  parameter int unsigned ENTRIES = fcce_pkg::ENTRIES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // request word
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        operation_i,
  input  logic [15:0]                       cluster_index_i,
  input  logic [15:0]                       entry_value_i,
  // result word
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [15:0]                       result_value_o,
  output logic [1:0]                        status_o,
  // scan_limit register write
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [fcce_pkg::SCAN_LIMIT_W-1:0] cfg_data_i
);
  import fcce_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic cfg_we;

  // Register writes are always taken, in any state
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  fcce_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  fcce_dpath #(
    .ENTRIES (ENTRIES)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cluster_index_i (cluster_index_i),
    .entry_value_i   (entry_value_i),
    .cfg_we_i        (cfg_we),
    .cfg_data_i      (cfg_data_i),
    .result_value_o  (result_value_o),
    .status_o        (status_o)
  );

endmodule

FILE: verif/fat_cluster_chain_engine_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FAT cluster chain engine testbench
// Drives read, write, allocate and free-chain request words into the engine.
// It keeps a shadow copy of the allocation table and the scan limit, and
// checks every result word in order against the shadow's prediction. The run
// covers several scan limits and random gaps on both sides.
// ----------------------------------------------------------------------------
module fat_cluster_chain_engine_core_tb;
  import fcce_pkg::*;

  localparam int unsigned ENTRIES        = ENTRIES_DEF;
  localparam int unsigned WATCHDOG_LIMIT = 40000;
  localparam int unsigned REPORT_MAX     = 10;

  typedef struct packed {
    op_e         op;
    logic [15:0] idx;
    logic [15:0] val;
  } fat_req_t;

  typedef struct packed {
    logic [15:0] value;
    status_e     code;
  } fat_reply_t;

  // Port-side signals
  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [1:0]              operation = '0;
  logic [15:0]             cluster_index = '0;
  logic [15:0]             entry_value = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [15:0]             result_value;
  logic [1:0]              status;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [SCAN_LIMIT_W-1:0] cfg_data = '0;

  // Shadow of the engine state
  logic [15:0]             fat_shadow [ENTRIES];
  logic [SCAN_LIMIT_W-1:0] scan_limit_shadow;

  // Request words waiting to go out, and result words owed by the engine
  fat_req_t   request_backlog [$];
  fat_reply_t fat_replies_due [$];
  fat_req_t   cur_req;

  bit          req_taken     = 1'b0;
  bit          sender_held   = 1'b0;
  bit          src_idle_en   = 1'b1;
  bit          snk_idle_en   = 1'b1;
  int unsigned src_gap       = 0;
  int unsigned snk_stall_left = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned failures      = 0;
  int unsigned words_checked = 0;
  int unsigned cfg_writes    = 0;
  int unsigned ops_seen    [4];
  int unsigned status_seen [4];

  fat_cluster_chain_engine_core #(
    .ENTRIES(ENTRIES)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .operation_i    (operation),
    .cluster_index_i(cluster_index),
    .entry_value_i  (entry_value),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .result_value_o (result_value),
    .status_o       (status),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_data_i     (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Bias indices towards the low clusters so chains and allocations collide,
  // but still hit the whole table and the whole 16-bit range.
  function automatic logic [15:0] pick_cluster();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 80) return 16'($urandom_range(2, 63));
    if (r < 90) return 16'($urandom_range(0, ENTRIES - 1));
    return 16'($urandom());
  endfunction

  function automatic logic [15:0] pick_entry_value();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 30) return 16'($urandom_range(2, 63));
    if (r < 50) return EOC_MARK;
    if (r < 60) return FREE_MARK;
    if (r < 70) return 16'($urandom_range(RESERVED_FIRST, 16'hFFFE));
    return 16'($urandom());
  endfunction

  function automatic void note_failure(input string what);
    failures++;
    if (failures <= REPORT_MAX) $display("[%0t] %s", $time, what);
  endfunction

  task automatic queue_request(input op_e op, input logic [15:0] idx,
                               input logic [15:0] val);
    fat_req_t r;
    r.op  = op;
    r.idx = idx;
    r.val = val;
    request_backlog.push_back(r);
  endtask

  // Apply one accepted request to the shadow table and owe its result word.
  task automatic apply_to_shadow_fat(input fat_req_t r);
    fat_reply_t  exp;
    int unsigned scan_end;
    int unsigned i;
    int unsigned c;
    int unsigned nxt;
    int unsigned steps;
    bit          done;
    exp.value = '0;
    exp.code  = STAT_OK;
    case (r.op)
      OP_READ: begin
        if (r.idx < ENTRIES) exp.value = fat_shadow[r.idx];
        else exp.code = STAT_RANGE;
      end
      OP_WRITE: begin
        if (r.idx < ENTRIES) fat_shadow[r.idx] = r.val;
        else exp.code = STAT_RANGE;
      end
      OP_ALLOC: begin
        // Search from the first data cluster up to the tightest bound.
        scan_end = scan_limit_shadow;
        if (scan_end > ENTRIES) scan_end = ENTRIES;
        if (scan_end > RESERVED_FIRST) scan_end = RESERVED_FIRST;
        exp.code = STAT_FULL;
        done = 1'b0;
        i = FIRST_DATA;
        while (!done && i < scan_end) begin
          if (fat_shadow[i] == FREE_MARK) begin
            fat_shadow[i] = EOC_MARK;
            exp.value = 16'(i);
            exp.code = STAT_OK;
            done = 1'b1;
          end
          i++;
        end
      end
      default: begin
        // Walk the chain, clearing as we go; read each link before clearing.
        c = r.idx;
        steps = 0;
        done = 1'b0;
        while (!done && c >= FIRST_DATA && c <= LAST_DATA) begin
          if (c >= ENTRIES) begin
            exp.code = STAT_RANGE;
            done = 1'b1;
          end else if (steps >= ENTRIES) begin
            exp.code = STAT_LONG;
            done = 1'b1;
          end else begin
            nxt = fat_shadow[c];
            fat_shadow[c] = FREE_MARK;
            c = nxt;
            steps++;
          end
        end
      end
    endcase
    fat_replies_due.push_back(exp);
  endtask

  // Driver: change request words at the falling edge, hold while stalled.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid || req_taken) begin
        req_taken = 1'b0;
        if (src_gap > 0) begin
          src_gap--;
          in_valid <= 1'b0;
        end else if (!sender_held && request_backlog.size() != 0) begin
          cur_req = request_backlog.pop_front();
          in_valid      <= 1'b1;
          operation     <= cur_req.op;
          cluster_index <= cur_req.idx;
          entry_value   <= cur_req.val;
          src_gap = src_idle_en ? gap_len() : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result side back-pressure: runs of stall, or none at all.
  always @(negedge clk_i) begin
    if (!snk_idle_en) begin
      out_stall <= 1'b0;
      snk_stall_left = 0;
    end else if (snk_stall_left > 0) begin
      out_stall <= 1'b1;
      snk_stall_left--;
    end else if ($urandom_range(99) < 70) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= 1'b1;
      snk_stall_left = gap_len();
    end
  end

  // Monitor: sample both handshakes at the rising edge. Predict before
  // checking so a word owed this edge is already queued.
  always @(posedge clk_i) begin
    fat_reply_t exp;
    bit         busy;
    busy = 1'b0;
    if (rst_ni && in_valid && !in_stall) begin
      apply_to_shadow_fat(cur_req);
      ops_seen[cur_req.op]++;
      req_taken = 1'b1;
      busy = 1'b1;
    end
    if (rst_ni && out_valid && !out_stall) begin
      busy = 1'b1;
      words_checked++;
      status_seen[status]++;
      if (fat_replies_due.size() == 0) begin
        note_failure($sformatf("result word with none owed: value %h status %0d",
                               result_value, status));
      end else begin
        exp = fat_replies_due.pop_front();
        if (result_value !== exp.value || status !== exp.code)
          note_failure($sformatf("mismatch: value exp %h got %h, status exp %0d got %0d",
                                 exp.value, result_value, exp.code, status));
      end
    end
    if (cfg_valid && cfg_ready) busy = 1'b1;
    // Drop out if nothing moves for far longer than the slowest request.
    if (busy) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles, %0d words owed",
                 quiet_cycles, fat_replies_due.size());
        $display("fat_cluster_chain_engine_core test failed");
        $finish;
      end
    end
  end

  // Wait until every word has gone out and every result has come back.
  task automatic wait_until_settled();
    do @(posedge clk_i);
    while (request_backlog.size() != 0 || in_valid || fat_replies_due.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_scan_limit(input logic [SCAN_LIMIT_W-1:0] limit);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= limit;
    do @(posedge clk_i);
    while (!cfg_ready);
    scan_limit_shadow = limit;
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // Random traffic, mostly well-formed chain lifecycles: link clusters up,
  // end with an end mark, read back, free from the head.
  task automatic queue_random_traffic(input int unsigned n);
    int unsigned count;
    int unsigned r;
    int unsigned len;
    int unsigned k;
    logic [15:0] head;
    logic [15:0] prev;
    logic [15:0] nxt;
    count = 0;
    while (count < n) begin
      r = $urandom_range(99);
      if (r < 35) begin
        len  = $urandom_range(1, 6);
        head = 16'($urandom_range(2, 63));
        prev = head;
        for (k = 1; k < len; k++) begin
          nxt = 16'($urandom_range(2, 63));
          queue_request(OP_WRITE, prev, nxt);
          prev = nxt;
        end
        queue_request(OP_WRITE, prev, EOC_MARK);
        count += len;
        if ($urandom_range(1)) begin
          queue_request(OP_READ, head, 16'($urandom()));
          count++;
        end
        if ($urandom_range(9) < 7) begin
          queue_request(OP_FREE, head, 16'($urandom()));
          count++;
        end
      end else if (r < 55) begin
        len = $urandom_range(1, 3);
        for (k = 0; k < len; k++) queue_request(OP_ALLOC, pick_cluster(), 16'($urandom()));
        count += len;
      end else if (r < 70) begin
        queue_request(OP_READ, pick_cluster(), 16'($urandom()));
        count++;
      end else if (r < 85) begin
        queue_request(OP_WRITE, pick_cluster(), pick_entry_value());
        count++;
      end else begin
        // Free from anywhere, special starts included.
        case ($urandom_range(5))
          0: head = 16'h0000;
          1: head = 16'h0001;
          2: head = 16'($urandom_range(RESERVED_FIRST, 16'hFFFF));
          3: head = LAST_DATA;
          default: head = pick_cluster();
        endcase
        queue_request(OP_FREE, head, 16'($urandom()));
        count++;
      end
    end
  endtask

  // One phase: settle, set the scan limit, then send random traffic. With
  // hold_mid set, stop the sender halfway until every result is back.
  task automatic run_phase(input logic [SCAN_LIMIT_W-1:0] limit, input int unsigned n,
                           input bit src_idle, input bit snk_idle, input bit hold_mid);
    wait_until_settled();
    write_scan_limit(limit);
    src_idle_en = src_idle;
    snk_idle_en = snk_idle;
    queue_random_traffic(n);
    if (hold_mid) begin
      do @(posedge clk_i);
      while (request_backlog.size() > n / 2);
      sender_held = 1'b1;
      do @(posedge clk_i);
      while (in_valid || fat_replies_due.size() != 0);
      repeat (8) @(posedge clk_i);
      sender_held = 1'b0;
    end
  endtask

  initial begin
    foreach (fat_shadow[i]) fat_shadow[i] = FREE_MARK;
    scan_limit_shadow = SCAN_LIMIT_RST;
    foreach (ops_seen[i]) ops_seen[i] = 0;
    foreach (status_seen[i]) status_seen[i] = 0;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // The engine sweeps its table after reset; the limit may be set meanwhile.
    write_scan_limit(13'd4096);

    // Directed: index extremes, out-of-range accesses, allocation from the
    // bottom, a clean chain free, a bad link and the non-chain starts.
    src_idle_en = 1'b0;
    snk_idle_en = 1'b0;
    queue_request(OP_READ,  16'h0000, 16'hFFFF);
    queue_request(OP_READ,  16'd4095, 16'h0000);
    queue_request(OP_READ,  16'hFFFF, 16'h0000);
    queue_request(OP_READ,  16'h1000, 16'h0000);
    queue_request(OP_WRITE, 16'h1000, 16'h1234);
    queue_request(OP_WRITE, 16'hFFFF, 16'hFFFF);
    queue_request(OP_WRITE, 16'd4095, 16'hFFFF);
    queue_request(OP_READ,  16'd4095, 16'h0000);
    queue_request(OP_ALLOC, 16'h0000, 16'h0000);
    queue_request(OP_ALLOC, 16'hFFFF, 16'hFFFF);
    queue_request(OP_WRITE, 16'd4, 16'd5);
    queue_request(OP_WRITE, 16'd5, 16'd6);
    queue_request(OP_WRITE, 16'd6, EOC_MARK);
    queue_request(OP_FREE,  16'd4, 16'h0000);
    queue_request(OP_READ,  16'd5, 16'h0000);
    queue_request(OP_FREE,  16'h0000, 16'h0000);
    queue_request(OP_FREE,  16'h0001, 16'h0000);
    queue_request(OP_FREE,  16'hFFF0, 16'h0000);
    queue_request(OP_FREE,  16'hFFFF, 16'h0000);
    queue_request(OP_WRITE, 16'd7, 16'h1000);
    queue_request(OP_FREE,  16'd7, 16'h0000);
    queue_request(OP_READ,  16'd7, 16'h0000);
    queue_request(OP_FREE,  LAST_DATA, 16'h0000);
    queue_request(OP_WRITE, 16'd9, 16'h5555);
    queue_request(OP_READ,  16'd9, 16'hAAAA);

    // Tightest limit: only cluster 2 is searched, and it is taken already.
    wait_until_settled();
    write_scan_limit(13'd3);
    queue_request(OP_ALLOC, 16'h0000, 16'h0000);
    queue_request(OP_FREE,  16'd2, 16'h0000);
    queue_request(OP_ALLOC, 16'h0000, 16'h0000);
    queue_request(OP_ALLOC, 16'h0000, 16'h0000);

    run_phase(13'd4096, 140, 1'b1, 1'b1, 1'b0);
    run_phase(13'd3, 60, 1'b1, 1'b0, 1'b0);
    run_phase(13'($urandom_range(4, 64)), 140, 1'b0, 1'b1, 1'b0);
    run_phase(13'd4095, 140, 1'b0, 1'b0, 1'b0);
    run_phase(13'($urandom_range(3, 4096)), 140, 1'b1, 1'b1, 1'b1);
    run_phase(13'd17, 120, 1'b1, 1'b1, 1'b0);

    wait_until_settled();
    repeat (20) @(posedge clk_i);
    if (fat_replies_due.size() != 0)
      note_failure($sformatf("%0d result words never arrived", fat_replies_due.size()));

    $display("Covered %0d requests (%0d read, %0d write, %0d allocate, %0d free) over %0d limits",
             words_checked, ops_seen[OP_READ], ops_seen[OP_WRITE], ops_seen[OP_ALLOC],
             ops_seen[OP_FREE], cfg_writes);
    $display("Status mix: %0d ok, %0d full, %0d out of range, %0d too long; %0d failures",
             status_seen[STAT_OK], status_seen[STAT_FULL], status_seen[STAT_RANGE],
             status_seen[STAT_LONG], failures);
    if (failures == 0) begin
      $display("fat_cluster_chain_engine_core test passed");
    end else begin
      $display("fat_cluster_chain_engine_core test failed");
    end
    $finish;
  end

endmodule
